### src/nves_pkg.sv
`default_nettype none

package nves_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);
  localparam int VALUE_W     = 32;
  localparam int DIFF_W      = VALUE_W + 2;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // stream widths
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 16;

  // operation codes carried in s_tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // classified command handed from front to back
  typedef struct packed {
    logic                      is_query;
    logic [ADDR_W-1:0]         index;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

### src/nves_front.sv
`default_nettype none

module nves_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [nves_pkg::S_TDATA_W-1:0]   s_tdata,
  input  wire logic                             s_tuser,
  output logic                                  push_valid,
  input  wire logic                             push_ready,
  output nves_pkg::cmd_t                        push_cmd
);
  import nves_pkg::*;

  logic stg_valid;
  cmd_t stg_cmd;

  // input stage takes a new transaction whenever it is empty or draining
  assign s_tready   = !stg_valid || push_ready;
  assign push_valid = stg_valid;
  assign push_cmd   = stg_cmd;

  // classify the incoming transaction and hold it for the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      stg_valid        <= 1'b1;
      stg_cmd.is_query <= (s_tuser == OP_QUERY);
      stg_cmd.index    <= s_tdata[ADDR_W-1:0];
      stg_cmd.value    <= $signed(s_tdata[ADDR_W +: VALUE_W]);
    end else if (push_ready) begin
      stg_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### src/nves_queue.sv
`default_nettype none

module nves_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire nves_pkg::cmd_t push_cmd,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output nves_pkg::cmd_t      pop_cmd
);
  import nves_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

### src/nves_back.sv
`default_nettype none

module nves_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [nves_pkg::LEN_W-1:0]     len,
  input  wire logic                           q_valid,
  output logic                                q_ready,
  input  wire nves_pkg::cmd_t                 q_cmd,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [nves_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic                                m_tuser
);
  import nves_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXP    = 3'd1;
  localparam logic [2:0] S_BIN    = 3'd2;
  localparam logic [2:0] S_FIN    = 3'd3;
  localparam logic [2:0] S_FIN_HI = 3'd4;
  localparam logic [2:0] S_FIN_LO = 3'd5;
  localparam logic [2:0] S_CMP    = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0]                state;
  logic [LEN_W-1:0]          lo;
  logic [LEN_W-1:0]          hi;
  logic [ADDR_W-1:0]         mid;
  logic [LEN_W-1:0]          n;
  logic signed [VALUE_W-1:0] qv;
  logic signed [VALUE_W-1:0] a_hi;
  logic signed [DIFF_W-1:0]  below;
  logic signed [DIFF_W-1:0]  above;
  logic [ADDR_W-1:0]         res_idx;
  logic                      res_empty;
  logic [ADDR_W-1:0]         out_idx;

  logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];
  logic signed [VALUE_W-1:0] rd_data;
  logic [ADDR_W-1:0]         rd_addr;
  logic                      mem_we;

  logic             less;
  logic [LEN_W-1:0] hi_dbl;
  logic [LEN_W-1:0] hi_raw;
  logic [LEN_W-1:0] srch_lo;
  logic [LEN_W-1:0] srch_hi;
  logic [LEN_W-1:0] mid_calc;
  logic             srch_go;
  logic             exp_cont;
  logic             start_exp;
  logic [LEN_W-1:0] lo_m1;
  logic [LEN_W-1:0] n_m1;

  assign q_ready = (state == S_IDLE);
  assign mem_we  = (state == S_IDLE) && q_valid && !q_cmd.is_query;
  assign m_tdata = {{(M_TDATA_W - ADDR_W){1'b0}}, out_idx};

  // probe comparison and bracket arithmetic
  assign less      = (rd_data < qv);
  assign hi_dbl    = {hi[LEN_W-2:0], 1'b0};
  assign exp_cont  = less && (hi_dbl < n);
  assign start_exp = (len > LEN_W'(1));
  assign lo_m1     = lo - 1'b1;
  assign n_m1      = n - 1'b1;

  // next bracket: start of a query, exit of the doubling phase, or a halving step
  always_comb begin
    hi_raw = hi;
    unique case (state)
      S_EXP: begin
        srch_lo = less ? hi : lo;
        hi_raw  = less ? hi_dbl : hi;
        srch_hi = (hi_raw > n) ? n : hi_raw;
      end
      S_BIN: begin
        srch_lo = less ? ({1'b0, mid} + LEN_W'(1)) : lo;
        srch_hi = less ? hi : {1'b0, mid};
      end
      default: begin
        srch_lo = '0;
        srch_hi = LEN_W'(1);
      end
    endcase
  end

  assign mid_calc = srch_lo + ((srch_hi - srch_lo) >> 1);
  assign srch_go  = (srch_lo < srch_hi);

  // read address for the next probe
  always_comb begin
    unique case (state)
      S_IDLE:   rd_addr = start_exp ? ADDR_W'(1) : mid_calc[ADDR_W-1:0];
      S_EXP:    rd_addr = exp_cont ? hi_dbl[ADDR_W-1:0] : mid_calc[ADDR_W-1:0];
      S_BIN:    rd_addr = mid_calc[ADDR_W-1:0];
      S_FIN:    rd_addr = lo[ADDR_W-1:0];
      S_FIN_HI: rd_addr = lo_m1[ADDR_W-1:0];
      default:  rd_addr = '0;
    endcase
  end

  // table memory, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_cmd.index] <= q_cmd.value;
    end
    rd_data <= mem[rd_addr];
  end

  // search sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid && q_cmd.is_query) begin
            qv        <= q_cmd.value;
            n         <= len;
            res_empty <= (len == '0);
            lo        <= '0;
            hi        <= LEN_W'(1);
            mid       <= '0;
            if (len == '0) begin
              res_idx   <= '0;
              state     <= S_OUT;
            end else if (start_exp) begin
              state <= S_EXP;
            end else begin
              state <= S_BIN;
            end
          end
        end
        S_EXP: begin
          if (exp_cont) begin
            lo <= hi;
            hi <= hi_dbl;
          end else begin
            lo    <= srch_lo;
            hi    <= srch_hi;
            mid   <= mid_calc[ADDR_W-1:0];
            state <= srch_go ? S_BIN : S_FIN;
          end
        end
        S_BIN: begin
          lo  <= srch_lo;
          hi  <= srch_hi;
          mid <= mid_calc[ADDR_W-1:0];
          if (!srch_go) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (lo >= n) begin
            res_idx <= n_m1[ADDR_W-1:0];
            state   <= S_OUT;
          end else if (lo == '0) begin
            res_idx <= '0;
            state   <= S_OUT;
          end else begin
            state <= S_FIN_HI;
          end
        end
        S_FIN_HI: begin
          a_hi  <= rd_data;
          state <= S_FIN_LO;
        end
        S_FIN_LO: begin
          if (a_hi == qv) begin
            res_idx <= lo[ADDR_W-1:0];
            state   <= S_OUT;
          end else begin
            below <= DIFF_W'(qv) - DIFF_W'(rd_data);
            above <= DIFF_W'(a_hi) - DIFF_W'(qv);
            state <= S_CMP;
          end
        end
        S_CMP: begin
          res_idx <= (below <= above) ? lo_m1[ADDR_W-1:0] : lo[ADDR_W-1:0];
          state   <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            out_idx  <= res_idx;
            m_tuser  <= res_empty;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### src/nearest_value_exponential_search_unit.sv
// channel   | group             | tdata (low bit up)             | tuser
// ----------+-------------------+--------------------------------+-----------------------
// input     | s_tvalid/s_tready | index[9:0], value[41:10]       | op (0 write, 1 query)
// output    | m_tvalid/m_tready | nearest_index[9:0]             | empty_res
// config    | cfg_wr_en         | cfg_wr_data: array_length      | -
//
// a write is stored while the search engine is idle; a query doubles a bound,
// runs a binary search and compares the two neighbours, with one table probe
// per cycle through the single registered memory read port.
// the front stage and a four-entry queue keep taking transactions while a
// query runs or a result waits on m_tready, until both are full.
// reset clears control state and array_length; table contents are
// undefined until written and get no clearing pass.
`default_nettype none

module nearest_value_exponential_search_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [nves_pkg::S_TDATA_W-1:0] s_tdata,   // index[9:0], value[41:10]
  input  wire logic                          s_tuser,   // op
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [nves_pkg::M_TDATA_W-1:0]     m_tdata,   // nearest_index[9:0]
  output logic                               m_tuser,   // empty_res
  input  wire logic                          cfg_wr_en,
  input  wire logic [nves_pkg::LEN_W-1:0]    cfg_wr_data
);
  import nves_pkg::*;

  logic [LEN_W-1:0] array_length;
  logic [LEN_W-1:0] len_sat;
  logic             push_valid;
  logic             push_ready;
  cmd_t             push_cmd;
  logic             q_valid;
  logic             q_ready;
  cmd_t             q_cmd;

  // length register; the search engine sees it saturated to the table depth
  always_ff @(posedge clk) begin
    if (rst) begin
      array_length <= '0;
    end else if (cfg_wr_en) begin
      array_length <= cfg_wr_data;
    end
  end

  assign len_sat = (array_length > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : array_length;

  nves_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  nves_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  nves_back u_back (
    .clk      (clk),
    .rst      (rst),
    .len      (len_sat),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

### src/nves_checker.sv
`default_nettype none

module nves_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [nves_pkg::M_TDATA_W-1:0] m_tdata,
  input wire logic                           m_tuser
);
  import nves_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // an empty table always reports index zero
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("empty result with nonzero index");

  // padding above the index stays clear
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[M_TDATA_W-1:ADDR_W] == '0)
    else $error("result padding set");

  // nothing is offered straight after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind nearest_value_exponential_search_unit nves_checker u_nves_checker (.*);

`default_nettype wire

### bench/tb_nearest_value_exponential_search_unit.sv
module tb_nearest_value_exponential_search_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import nves_pkg::*;

  localparam longint VALUE_MAX  = 64'sd2147483647;
  localparam longint VALUE_MIN  = -64'sd2147483648;
  localparam int     DRAIN_WAIT = 40;     // longer than the slowest query
  localparam int     LONG_HOLD  = 300;
  localparam int     STALL_LIMIT = 3000;

  // one input transaction: table write or nearest query
  typedef struct packed {
    logic                      op;
    logic [ADDR_W-1:0]         index;
    logic signed [VALUE_W-1:0] value;
  } search_item_t;

  // one answer of a nearest query
  typedef struct packed {
    logic [ADDR_W-1:0] nearest;
    logic              empty;
  } nearest_answer_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;   // index[9:0], value[41:10]
  logic                 s_tuser = 1'b0; // op
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;        // nearest_index[9:0]
  logic                 m_tuser;        // empty_res
  logic                 cfg_wr_en = 1'b0;
  logic [LEN_W-1:0]     cfg_wr_data = '0;

  nearest_value_exponential_search_unit dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // shadow of the block: table as accepted, and the length register
  int              shadow_values [TABLE_DEPTH];
  int unsigned     shadow_length = 0;
  // table as it will be once every queued write is taken, used to aim queries
  int              planned_values [TABLE_DEPTH];

  search_item_t    pending_items [$];
  nearest_answer_t expected_answers [$];
  search_item_t    cur_item;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned writes_taken = 0;
  int unsigned queries_taken = 0;
  int unsigned answers_checked = 0;
  int unsigned mismatches = 0;
  int unsigned long_holds = 0;
  int unsigned hold_left = 0;
  int unsigned lengths_written = 0;
  int unsigned idle_cycles = 0;
  logic [7:0]  ready_pattern = 8'hff;
  int unsigned pattern_age = 0;

  function automatic int clamp32(input longint x);
    if (x > VALUE_MAX) return int'(VALUE_MAX);
    if (x < VALUE_MIN) return int'(VALUE_MIN);
    return int'(x);
  endfunction

  // exponential bound doubling, lower-bound binary search, neighbour compare
  function automatic nearest_answer_t nearest_entry(input longint v, input int unsigned len);
    nearest_answer_t ans;
    int unsigned     n, lo, hi, mid;
    longint          below, above;
    ans.nearest = '0;
    ans.empty   = 1'b0;
    n = (len > TABLE_DEPTH) ? TABLE_DEPTH : len;
    if (n == 0) begin
      ans.empty = 1'b1;
      return ans;
    end
    lo = 0;
    hi = 1;
    while (hi < n && longint'(shadow_values[hi]) < v) begin
      lo = hi;
      hi = hi << 1;
    end
    if (hi > n) hi = n;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (longint'(shadow_values[mid]) < v) lo = mid + 1;
      else hi = mid;
    end
    if (lo >= n) begin
      lo = n - 1;
    end else if (lo != 0 && longint'(shadow_values[lo]) != v) begin
      below = v - longint'(shadow_values[lo - 1]);
      above = longint'(shadow_values[lo]) - v;
      if (below <= above) lo = lo - 1;
    end
    ans.nearest = lo[ADDR_W-1:0];
    return ans;
  endfunction

  task automatic push_write(input int unsigned idx, input int val);
    search_item_t it;
    it.op    = OP_WRITE;
    it.index = idx[ADDR_W-1:0];
    it.value = val;
    planned_values[idx] = val;
    pending_items.push_back(it);
  endtask

  task automatic push_query(input int val);
    search_item_t it;
    int unsigned  junk_index;
    junk_index = $urandom_range(0, TABLE_DEPTH - 1);
    it.op    = OP_QUERY;
    it.index = junk_index[ADDR_W-1:0];
    it.value = val;
    pending_items.push_back(it);
  endtask

  // query values aimed at stored entries, neighbours, midpoints and spreads, or random and extreme
  function automatic int pick_query_value(input int unsigned len);
    int unsigned n, k;
    longint      e, spread;
    n = (len > TABLE_DEPTH) ? TABLE_DEPTH : len;
    k = $urandom_range(0, n - 1);
    e = planned_values[k];
    spread = $urandom_range(0, 1) ? 1000 : 4000000;
    case ($urandom_range(0, 9))
      0, 1: return int'($urandom);
      2: return planned_values[k];
      3: return clamp32($urandom_range(0, 1) ? e + 1 : e - 1);
      4: begin
        if (k > 0) return clamp32((longint'(planned_values[k - 1]) + e) >>> 1);
        return clamp32(e - 1);
      end
      5: return $urandom_range(0, 1) ? int'(VALUE_MAX) : int'(VALUE_MIN);
      default: return clamp32(e + longint'($urandom_range(0, 2 * spread)) - spread);
    endcase
  endfunction

  // sorted run from index 0 with random steps, duplicates now and then
  task automatic fill_sorted(input int unsigned count, input longint start,
                             input int unsigned max_step);
    longint acc;
    acc = start;
    for (int unsigned i = 0; i < count; i++) begin
      push_write(i, clamp32(acc));
      if ($urandom_range(0, 7) != 0) acc += $urandom_range(0, max_step);
    end
  endtask

  // queries with the odd stray write; below noise_from a write keeps the entry
  task automatic query_batch(input int unsigned count, input int unsigned noise_from);
    int unsigned idx;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        if (noise_from >= TABLE_DEPTH) begin
          idx = $urandom_range(0, TABLE_DEPTH - 1);
          push_write(idx, planned_values[idx]);
        end else begin
          idx = $urandom_range(noise_from, TABLE_DEPTH - 1);
          push_write(idx, int'($urandom));
        end
      end
      push_query(pick_query_value(shadow_length));
    end
  endtask

  // sender pause: wait until every transaction is taken and answered
  task automatic drain();
    @(negedge clk);
    while (pending_items.size() != 0 || s_tvalid || expected_answers.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_length(input int unsigned len);
    drain();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len[LEN_W-1:0];
    shadow_length = len;
    lengths_written++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // driver: bursts from the pending queue, prediction on each transaction
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (cur_item.op == OP_WRITE) begin
          shadow_values[cur_item.index] = cur_item.value;
          writes_taken++;
        end else begin
          expected_answers.push_back(nearest_entry(longint'(cur_item.value), shadow_length));
          queries_taken++;
        end
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          cur_item = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {{(S_TDATA_W - ADDR_W - VALUE_W){1'b0}}, cur_item.value, cur_item.index};
          s_tuser  <= cur_item.op;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each answer, then choose the next ready level
  always @(posedge clk) begin
    nearest_answer_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_answers.size() == 0) begin
          $error("answer with no query outstanding: nearest_index %0d empty_res %0b",
                 m_tdata[ADDR_W-1:0], m_tuser);
          mismatches++;
        end else begin
          want = expected_answers.pop_front();
          answers_checked++;
          if (m_tdata[ADDR_W-1:0] !== want.nearest) begin
            $error("nearest_index: expected %0d, got %0d", want.nearest, m_tdata[ADDR_W-1:0]);
            mismatches++;
          end
          if (m_tuser !== want.empty) begin
            $error("empty_res: expected %0b, got %0b", want.empty, m_tuser);
            mismatches++;
          end
        end
      end
      // long hold-off while the sender still has plenty queued
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (long_holds < 2 && answers_checked >= (long_holds == 0 ? 20 : 200) &&
                   pending_items.size() >= 12) begin
        hold_left = LONG_HOLD;
        long_holds++;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ready_pattern[0];
        if (pattern_age == 63) begin
          pattern_age = 0;
          ready_pattern = ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom);
        end else begin
          pattern_age++;
          ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
        end
      end
    end
  end

  // watchdog on cycles with no transaction on any port
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
      idle_cycles = 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    int unsigned n;
    for (int i = 0; i < TABLE_DEPTH; i++) planned_values[i] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty table, then a short table with extremes, duplicates and ties
    set_length(0);
    push_query(int'(VALUE_MIN));
    push_query(int'(VALUE_MAX));
    push_query(0);
    push_write(0, int'(VALUE_MIN));
    push_write(1, -100);
    push_write(2, -10);
    push_write(3, -10);
    push_write(4, 0);
    push_write(5, 10);
    push_write(6, 20);
    push_write(7, int'(VALUE_MAX));
    push_write(TABLE_DEPTH - 1, 5);
    set_length(8);
    push_query(int'(VALUE_MIN));   // exact match on the lowest entry
    push_query(-2147483647);
    push_query(-55);               // tie, lower index wins
    push_query(-10);               // duplicate, first position
    push_query(-11);
    push_query(15);                // tie between 10 and 20
    push_query(int'(VALUE_MAX));
    push_query(2147483646);
    push_query(1073741824);
    set_length(6);
    push_query(int'(VALUE_MAX));   // above every element
    push_query(0);
    set_length(1);
    push_query(int'(VALUE_MAX));
    push_query(int'(VALUE_MIN));

    // whole table sorted across the full value range
    fill_sorted(TABLE_DEPTH, VALUE_MIN, 4100000);
    push_write(TABLE_DEPTH - 1, int'(VALUE_MAX));

    // long lengths, including the saturating ones
    set_length(TABLE_DEPTH);
    query_batch(28, TABLE_DEPTH);
    set_length(2047);
    query_batch(4, TABLE_DEPTH);
    set_length(TABLE_DEPTH + 1);
    query_batch(4, TABLE_DEPTH);
    set_length(TABLE_DEPTH - 1);
    query_batch(4, TABLE_DEPTH);
    set_length(2);
    query_batch(4, TABLE_DEPTH);
    set_length($urandom_range(513, 1000));
    query_batch(4, TABLE_DEPTH);
    set_length($urandom_range(3, TABLE_DEPTH));
    query_batch(4, TABLE_DEPTH);

    // short tables refilled each time, dense or sparse
    for (int p = 0; p < 3; p++) begin
      n = (p == 0) ? 1 : (p == 1) ? 2 : $urandom_range(3, 16);
      set_length(n);
      case ($urandom_range(0, 2))
        0: fill_sorted(n, longint'(int'($urandom)), 3);
        1: fill_sorted(n, longint'(int'($urandom)), 1000);
        default: fill_sorted(n, VALUE_MIN + $urandom_range(0, 1000), 200000000);
      endcase
      query_batch(8, n);
    end

    // unsorted content: the search steps still decide the answer
    n = $urandom_range(5, 12);
    set_length(n);
    for (int unsigned i = 0; i < n; i++) push_write(i, int'($urandom));
    query_batch(8, n);

    // back to an empty table
    set_length(0);
    push_query(int'($urandom));
    push_query(int'(VALUE_MIN));
    push_query(int'(VALUE_MAX));
    drain();

    $display("covered %0d table writes and %0d queries over %0d length settings",
             writes_taken, queries_taken, lengths_written);
    $display("checked %0d answers, receiver held off for long stretches %0d times",
             answers_checked, long_holds);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
